// ===== rtl/bfsp_pkg.sv =====
package bfsp_pkg;

   // Sizing
   localparam int MAX_NODES      = 64;
   localparam int MAX_EDGES      = 1024;
   localparam int WEIGHT_BITS    = 16;
   localparam int DIST_BITS      = 22;
   localparam int NODE_BITS      = $clog2(MAX_NODES);
   localparam int NODE_CNT_BITS  = $clog2(MAX_NODES + 1);
   localparam int EDGE_ADDR_BITS = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CNT_BITS  = $clog2(MAX_EDGES + 1);
   localparam int SUM_BITS       = DIST_BITS + 1;

   // Port widths
   localparam int REQ_DATA_BITS  = 32;
   localparam int RSP_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODE_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_NODE = 1'b1;

   // One stored edge
   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] weight;
      logic [NODE_BITS-1:0]          head;
      logic [NODE_BITS-1:0]          tail;
   } edge_rec_type;

   // One distance entry
   typedef struct packed {
      logic                        ok;
      logic signed [DIST_BITS-1:0] val;
   } dist_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_EFETCH,
      ST_DREAD,
      ST_CALC,
      ST_OREAD,
      ST_OLOAD,
      ST_OSEND
   } state_type;

endpackage

// ===== rtl/bellman_ford_shortest_paths_unit.sv =====
// Single-source shortest paths over a directed, weighted edge list.
// req_ channel: one edge per transfer (tuser = edge present, tlast = end of
// graph). Edges are stored in load order, up to 1024; further ones are dropped.
// csr_ channel: index 0 = node count (1..64), index 1 = source node. Always
// ready; write only while the block is idle.
// After the transfer marked tlast the block clears the distance table, one
// entry per node, then makes node_count-1 passes over the stored edges, each
// edge going through the edge memory read, the distance memory read and the
// shared add/clamp/compare unit one after another. It then streams one
// rsp_ result per node, in node order, tlast on the final node; the next
// node's distance is read only once the previous result has been taken.
// req_tready is low from the tlast transfer until the last result is taken;
// a stalled result holds in its output register. The edge count then returns
// to zero so the next transfer begins a new graph.
// Reset sets node count 1, source 0, empties the edge list and idles.
module bellman_ford_shortest_paths_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Edge input
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [5:0] edge_from, [11:6] edge_to, [27:12] edge_weight, [31:28] zero
   input  logic [bfsp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [0] edge_valid
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   // Result output
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [5:0] node_index, [27:6] distance, [31:28] zero
   output logic [bfsp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // [0] reachable
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   // Register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bfsp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bfsp_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import bfsp_pkg::*;

   // Memories
   edge_rec_type   edge_mem [MAX_EDGES];
   dist_entry_type dist_mem [MAX_NODES];

   state_type state_ff, state_in;

   logic [NODE_CNT_BITS-1:0] node_count_ff;
   logic [NODE_BITS-1:0]     source_ff;
   logic [NODE_CNT_BITS-1:0] n_ff, n_in;
   logic [NODE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NODE_CNT_BITS-1:0] pass_ff, pass_in;
   logic [EDGE_CNT_BITS-1:0] eidx_ff, eidx_in;
   logic [EDGE_CNT_BITS-1:0] edge_total_ff, edge_total_in;

   edge_rec_type   edge_rd_ff;
   dist_entry_type dist_a_ff, dist_b_ff;

   logic [NODE_BITS-1:0]   rsp_node_ff;
   logic                   rsp_ok_ff;
   logic [DIST_BITS-1:0]   rsp_dist_ff;
   logic                   rsp_last_ff;

   // Memory controls
   logic                      dist_we;
   logic [NODE_BITS-1:0]      dist_wr_addr;
   dist_entry_type            dist_wr_data;
   logic [NODE_BITS-1:0]      dist_rd_a_addr;
   logic [NODE_BITS-1:0]      dist_rd_b_addr;
   logic [EDGE_ADDR_BITS-1:0] edge_rd_addr;

   logic req_xfer, rsp_xfer, store_edge;
   logic init_done, edge_last, pass_last, out_last, run_passes;
   logic tail_in_range, head_in_range, relax, better;
   logic signed [SUM_BITS-1:0]  sum;
   logic signed [DIST_BITS-1:0] cand;
   edge_rec_type req_edge;
   logic [NODE_CNT_BITS-1:0] clamped_count;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign store_edge = req_xfer && req_tuser &&
                       (edge_total_ff < EDGE_CNT_BITS'(MAX_EDGES));

   assign req_edge.tail   = req_tdata[NODE_BITS-1:0];
   assign req_edge.head   = req_tdata[2*NODE_BITS-1:NODE_BITS];
   assign req_edge.weight = req_tdata[2*NODE_BITS+WEIGHT_BITS-1:2*NODE_BITS];

   // Node count in use: zero counts as one, large values cap at the table size
   always_comb begin
      if (node_count_ff == '0) begin
         clamped_count = NODE_CNT_BITS'(1);
      end else if (node_count_ff > NODE_CNT_BITS'(MAX_NODES)) begin
         clamped_count = NODE_CNT_BITS'(MAX_NODES);
      end else begin
         clamped_count = node_count_ff;
      end
   end

   // Sequencing conditions
   assign init_done  = (cnt_ff + NODE_CNT_BITS'(1)) == n_ff;
   assign out_last   = (cnt_ff + NODE_CNT_BITS'(1)) == n_ff;
   assign edge_last  = (eidx_ff + EDGE_CNT_BITS'(1)) == edge_total_ff;
   assign pass_last  = (pass_ff + NODE_CNT_BITS'(1)) == n_ff;
   assign run_passes = (n_ff > NODE_CNT_BITS'(1)) && (edge_total_ff != '0);

   // Shared relax unit: saturating add, then compare against the head
   assign sum = SUM_BITS'(dist_a_ff.val) + SUM_BITS'(edge_rd_ff.weight);
   always_comb begin
      if (sum[SUM_BITS-1] != sum[SUM_BITS-2]) begin
         cand = sum[SUM_BITS-1] ? {1'b1, {(DIST_BITS-1){1'b0}}}
                                : {1'b0, {(DIST_BITS-1){1'b1}}};
      end else begin
         cand = sum[DIST_BITS-1:0];
      end
   end
   assign tail_in_range = {1'b0, edge_rd_ff.tail} < n_ff;
   assign head_in_range = {1'b0, edge_rd_ff.head} < n_ff;
   assign better        = !dist_b_ff.ok || (dist_b_ff.val > cand);
   assign relax         = tail_in_range && head_in_range && dist_a_ff.ok && better;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tlast) state_in = ST_INIT;
         end
         ST_INIT: begin
            if (init_done) state_in = run_passes ? ST_EFETCH : ST_OREAD;
         end
         ST_EFETCH: state_in = ST_DREAD;
         ST_DREAD:  state_in = ST_CALC;
         ST_CALC: begin
            state_in = (edge_last && pass_last) ? ST_OREAD : ST_EFETCH;
         end
         ST_OREAD:  state_in = ST_OLOAD;
         ST_OLOAD:  state_in = ST_OSEND;
         ST_OSEND: begin
            if (rsp_xfer) state_in = out_last ? ST_IDLE : ST_OREAD;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: memory controls
   always_comb begin
      dist_we        = 1'b0;
      dist_wr_addr   = edge_rd_ff.head;
      dist_wr_data   = '{ok: 1'b1, val: cand};
      dist_rd_a_addr = edge_rd_ff.tail;
      dist_rd_b_addr = edge_rd_ff.head;
      edge_rd_addr   = eidx_ff[EDGE_ADDR_BITS-1:0];
      case (state_ff)
         ST_INIT: begin
            dist_we         = 1'b1;
            dist_wr_addr    = cnt_ff[NODE_BITS-1:0];
            dist_wr_data.ok = (cnt_ff[NODE_BITS-1:0] == source_ff);
            dist_wr_data.val = '0;
         end
         ST_CALC: begin
            dist_we = relax;
         end
         ST_OREAD, ST_OLOAD, ST_OSEND: begin
            dist_rd_a_addr = cnt_ff[NODE_BITS-1:0];
         end
         default: begin
            dist_we = 1'b0;
         end
      endcase
   end

   // Counter updates
   always_comb begin
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      pass_in       = pass_ff;
      eidx_in       = eidx_ff;
      edge_total_in = edge_total_ff;
      case (state_ff)
         ST_IDLE: begin
            if (store_edge) edge_total_in = edge_total_ff + EDGE_CNT_BITS'(1);
            if (req_xfer && req_tlast) begin
               n_in   = clamped_count;
               cnt_in = '0;
            end
         end
         ST_INIT: begin
            cnt_in = cnt_ff + NODE_CNT_BITS'(1);
            if (init_done) begin
               cnt_in  = '0;
               pass_in = NODE_CNT_BITS'(1);
               eidx_in = '0;
            end
         end
         ST_CALC: begin
            eidx_in = eidx_ff + EDGE_CNT_BITS'(1);
            if (edge_last) begin
               eidx_in = '0;
               pass_in = pass_ff + NODE_CNT_BITS'(1);
            end
         end
         ST_OSEND: begin
            if (rsp_xfer) begin
               cnt_in = cnt_ff + NODE_CNT_BITS'(1);
               if (out_last) edge_total_in = '0;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_CNT_BITS'(1);
         source_ff     <= '0;
         n_ff          <= NODE_CNT_BITS'(1);
         cnt_ff        <= '0;
         pass_ff       <= '0;
         eidx_ff       <= '0;
         edge_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         n_ff          <= n_in;
         cnt_ff        <= cnt_in;
         pass_ff       <= pass_in;
         eidx_ff       <= eidx_in;
         edge_total_ff <= edge_total_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NODE_COUNT:  node_count_ff <= csr_data[NODE_CNT_BITS-1:0];
               CSR_SOURCE_NODE: source_ff     <= csr_data[NODE_BITS-1:0];
               default:         source_ff     <= source_ff;
            endcase
         end
      end
   end

   // Edge memory
   always_ff @(posedge clock) begin
      if (store_edge) edge_mem[edge_total_ff[EDGE_ADDR_BITS-1:0]] <= req_edge;
   end

   always_ff @(posedge clock) begin
      edge_rd_ff <= edge_mem[edge_rd_addr];
   end

   // Distance memory: one write port, two read ports
   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_wr_addr] <= dist_wr_data;
   end

   always_ff @(posedge clock) begin
      dist_a_ff <= dist_mem[dist_rd_a_addr];
      dist_b_ff <= dist_mem[dist_rd_b_addr];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_OLOAD) begin
         rsp_node_ff <= cnt_ff[NODE_BITS-1:0];
         rsp_ok_ff   <= dist_a_ff.ok;
         rsp_dist_ff <= dist_a_ff.ok ? dist_a_ff.val : '0;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = (state_ff == ST_OSEND);
   assign rsp_tdata  = {(RSP_DATA_BITS-NODE_BITS-DIST_BITS)'(0), rsp_dist_ff, rsp_node_ff};
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input accepted while a result is pending");

   a_edge_total_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= EDGE_CNT_BITS'(MAX_EDGES))
      else $error("edge count beyond store depth");

   a_relax_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) && dist_we |-> ({1'b0, dist_wr_addr} < n_ff))
      else $error("distance write to a node outside the graph");

   a_last_is_final_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> ({1'b0, rsp_node_ff} + NODE_CNT_BITS'(1)) == n_ff)
      else $error("last flag on a node other than the final one");

   a_graph_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_tlast |=> req_tready && (edge_total_ff == '0))
      else $error("edge list not emptied after the final result");
`endif

endmodule
